>>> rtl/leb_pkg.sv
package leb_pkg;

    // Capacity of the text store in characters.
    localparam int DEPTH = 128;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [2:0] {
        K_FWD   = 3'd0,
        K_BACK  = 3'd1,
        K_END   = 3'd2,
        K_START = 3'd3,
        K_INS   = 3'd4,
        K_DEL   = 3'd5,
        K_READ  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_in;
        logic [6:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0] length_now;
        logic [7:0] cursor_now;
        logic [7:0] char_out;
        logic       overflow;
    } res_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

>>> rtl/leb_ram.sv
module leb_ram #(
    parameter int DATA_W  = 8,
    parameter int N_WORDS = 128
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((N_WORDS > 1) ? $clog2(N_WORDS) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                             wdata,
    input  logic                                          re,
    input  logic [((N_WORDS > 1) ? $clog2(N_WORDS) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                             rdata
);

    logic [DATA_W-1:0] mem_reg [N_WORDS];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/leb_seq.sv
module leb_seq
    import leb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    output res_t       fin,
    output logic       fin_valid,
    input  logic       fin_take,
    output ram_req_t   ram,
    input  logic [7:0] rdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_WR   = 5'b00100,
        S_PUT  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] length_reg, length_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             ins_reg, ins_next;
    logic [7:0]       ch_reg, ch_next;
    logic             hit_reg, hit_next;
    logic             ovf_reg, ovf_next;

    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        cursor_next = cursor_reg;
        ptr_next    = ptr_reg;
        ins_next    = ins_reg;
        ch_next     = ch_reg;
        hit_next    = hit_reg;
        ovf_next    = ovf_reg;
        ram         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    hit_next   = 1'b0;
                    ovf_next   = 1'b0;
                    ins_next   = 1'b0;
                    ch_next    = cmd.char_in;
                    state_next = S_DONE;
                    case (cmd.kind)
                        K_FWD:
                        begin
                            if (cursor_reg < length_reg)
                            begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        K_BACK:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - 1'b1;
                            end
                        end
                        K_END:
                        begin
                            cursor_next = length_reg;
                        end
                        K_START:
                        begin
                            cursor_next = '0;
                        end
                        K_INS:
                        begin
                            ins_next = 1'b1;
                            if (length_reg == CNT_W'(DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (length_reg > cursor_reg)
                            begin
                                // Shift the tail right starting from the last character.
                                ptr_next   = IDX_W'(length_reg - 1'b1);
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        K_DEL:
                        begin
                            if (cursor_reg < length_reg)
                            begin
                                if (cursor_reg + 1'b1 < length_reg)
                                begin
                                    ptr_next   = IDX_W'(cursor_reg + 1'b1);
                                    state_next = S_RD;
                                end
                                else
                                begin
                                    length_next = length_reg - 1'b1;
                                end
                            end
                        end
                        K_READ:
                        begin
                            if (CMP_W'(cmd.read_index) < CMP_W'(length_reg))
                            begin
                                hit_next   = 1'b1;
                                ptr_next   = IDX_W'(cmd.read_index);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                ram.re     = 1'b1;
                ram.raddr  = ptr_reg;
                state_next = hit_reg ? S_DONE : S_WR;
            end
            S_WR:
            begin
                ram.we    = 1'b1;
                ram.wdata = rdata;
                if (ins_reg)
                begin
                    ram.waddr = ptr_reg + 1'b1;
                    if (CNT_W'(ptr_reg) == cursor_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    ram.waddr = ptr_reg - 1'b1;
                    if (CNT_W'(ptr_reg) + 1'b1 == length_reg)
                    begin
                        length_next = length_reg - 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_PUT:
            begin
                ram.we      = 1'b1;
                ram.waddr   = IDX_W'(cursor_reg);
                ram.wdata   = ch_reg;
                length_next = length_reg + 1'b1;
                cursor_next = cursor_reg + 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (fin_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            length_reg <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        ins_reg <= ins_next;
        ch_reg  <= ch_next;
        hit_reg <= hit_next;
        ovf_reg <= ovf_next;
    end

    assign cmd_stall      = (state_reg != S_IDLE);
    assign fin_valid      = (state_reg == S_DONE);
    assign fin.length_now = 8'(length_reg);
    assign fin.cursor_now = 8'(cursor_reg);
    // The read data register is only loaded in the read state, so it holds while done waits.
    assign fin.char_out   = hit_reg ? rdata : 8'd0;
    assign fin.overflow   = ovf_reg;

`ifndef SYNTH
    a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= length_reg)
        else $error("cursor beyond text length");

    a_length_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= CNT_W'(DEPTH))
        else $error("text length beyond capacity");

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram.we && ram.re))
        else $error("store read and written in the same cycle");

    a_shift_keeps_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |=> $stable(length_reg) && $stable(cursor_reg))
        else $error("length or cursor changed during a store read");
`endif

endmodule

>>> rtl/line_edit_buffer_with_cursor.sv
// Channel  Direction  Handshake              Word
// cmd      in         cmd_valid / cmd_stall  cmd_t: kind, char_in, read_index
// res      out        res_valid / res_stall  res_t: length_now, cursor_now, char_out, overflow
//
// Cursor moves, unused kinds, rejected inserts and reads past the text go from idle straight
// to done; other reads pass one store read, deletes a read and a write per character after
// the deleted one, and inserts a read and a write per character behind the cursor, then a put.
// The tail shift is bound by the single port pair of the text store: one read, then one write.
// Reset clears length, cursor and the sequencer; the text store is not cleared.
// A stalled result sits in the output register while the next command is taken in.
module line_edit_buffer_with_cursor
    import leb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_stall,
    output res_t res,
    output logic res_valid,
    input  logic res_stall
);

    res_t       fin;
    logic       fin_valid;
    logic       fin_take;
    ram_req_t   ram;
    logic [7:0] rdata;

    res_t       res_reg, res_next;
    logic       res_valid_reg, res_valid_next;

    leb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .fin       (fin),
        .fin_valid (fin_valid),
        .fin_take  (fin_take),
        .ram       (ram),
        .rdata     (rdata)
    );

    leb_ram #(
        .DATA_W  (8),
        .N_WORDS (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

    assign fin_take = fin_valid && (!res_valid_reg || !res_stall);

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (fin_take)
        begin
            res_next       = fin;
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule
